>>> sv/sbc_pkg.sv
// Package for the 4bpp sprite blitter: command codes, FSM states, palette defaults.
// No dependencies.
package sbc_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_SCAN  = 2'd2,
      CMD_PAL   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_FLIPH  = 3'd2,
      CSR_FLIPV  = 3'd3,
      CSR_BACKGR = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX0,
      ST_PIX1,
      ST_SCAN,
      ST_OUT
   } state_type;

   function automatic logic [23:0] default_colour(input logic [3:0] slot);
      logic [23:0] c;
      case (slot)
         4'd2:    c = 24'h888888;
         4'd3:    c = 24'hBF3932;
         4'd4:    c = 24'hDE7AAE;
         4'd5:    c = 24'h4C3D21;
         4'd6:    c = 24'h905F25;
         4'd7:    c = 24'hE49452;
         4'd8:    c = 24'hEAD979;
         4'd9:    c = 24'h537A3B;
         4'd10:   c = 24'hABD54A;
         4'd11:   c = 24'h252E38;
         4'd12:   c = 24'h00467F;
         4'd13:   c = 24'h68ABCC;
         4'd14:   c = 24'hBCDEE4;
         4'd15:   c = 24'hFFFFFF;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage

>>> sv/sbc_if.sv
// Handshake channel interfaces for requests, responses and register writes.
// Depends on nothing.
interface sbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;
   logic [7:0]  sprite_data;
   logic [16:0] pixel_address;
   logic [3:0]  palette_slot;
   logic [23:0] palette_colour;
   modport source (output valid, cmd, origin_x, origin_y, sprite_data, pixel_address,
                   palette_slot, palette_colour, input ready);
   modport sink (input valid, cmd, origin_x, origin_y, sprite_data, pixel_address,
                 palette_slot, palette_colour, output ready);
endinterface

interface sbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        collided;
   logic        sprite_done;
   logic [23:0] scan_colour;
   logic        frame_end;
   modport source (output valid, collided, sprite_done, scan_colour, frame_end,
                   input ready);
   modport sink (input valid, collided, sprite_done, scan_colour, frame_end,
                 output ready);
endinterface

interface sbc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [7:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sbc_frame_mem.sv
// Frame store: single-port synchronous memory of 4-bit indices, registered read.
// Depends on nothing.
module sbc_frame_mem #(
   parameter int DEPTH = 76800,
   parameter int AW    = 17
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [3:0]    wdata,
   output logic [3:0]    rdata
);
   logic [3:0] mem [DEPTH];

   // Read-first port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> sv/sprite_blitter_4bpp_collision.sv
// Sprite blitter, one item at a time. After a request transfer the FSM runs IDLE, OUT
// for a sprite start, palette write or byte past the walk's end; IDLE, SCAN, OUT for
// a scanout read; and IDLE, PIX0, PIX1, OUT for a drawing byte (read-modify-write of
// two pixels on one memory port). The response is set in OUT and held until taken.
// After reset a clearing pass writes SCREEN_WIDTH*SCREEN_HEIGHT zeros, one per cycle,
// before the first request; control registers reset to zero, palette to its defaults.
module sprite_blitter_4bpp_collision #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input logic clock,
   input logic reset,
   sbc_req_if.sink   req,
   sbc_rsp_if.source rsp,
   sbc_csr_if.sink   csr
);
   import sbc_pkg::*;

   localparam int FRAME = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW = (FRAME > 131072) ? $clog2(FRAME) : 17;

   state_type state_ff, state_in;

   // Registers.
   logic [7:0] width_ff;
   logic [7:0] height_ff;
   logic       fliph_ff, flipv_ff;
   logic [3:0] bg_ff;
   logic signed [15:0] ox_ff, oy_ff;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic       coll_ff, coll_in;
   logic [23:0] pal_ff [16];

   // Per-item work registers.
   logic [7:0]  data_ff;
   logic [AW-1:0] clr_ff;
   logic        vis0_ff, vis1_ff;
   logic [AW-1:0] addr0_ff, addr1_ff;
   logic        last_ff;
   logic        done_ff;
   logic [16:0] req_addr_hold;
   logic        was_byte_ff;

   // Output register.
   logic        rv_ff;
   logic        oc_ff, od_ff, of_ff;
   logic [23:0] os_ff;

   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [3:0]  mem_wd, mem_rd;

   sbc_frame_mem #(.DEPTH(FRAME), .AW(AW)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_rd)
   );

   logic req_xfer;
   logic walk_active;
   assign req.ready   = (state_ff == ST_IDLE) && !rv_ff;
   assign req_xfer    = req.valid && req.ready;
   assign csr.ready   = 1'b1;
   assign walk_active = (width_ff != 8'd0) && (row_ff < height_ff);

   // Pixel placement for the current byte, computed on the request transfer.
   logic signed [19:0] dy, py, dx0, dx1, px0, px1;
   logic        v0, v1;
   logic [AW+10:0] a0w, a1w;
   always_comb begin
      dy  = flipv_ff ? 20'(signed'({1'b0, height_ff})) - 20'sd1 - 20'(signed'({1'b0, row_ff}))
                     : 20'(signed'({1'b0, row_ff}));
      dx0 = fliph_ff ? 20'(signed'({1'b0, width_ff, 1'b0})) - 20'sd1
                       - 20'(signed'({1'b0, col_ff, 1'b0}))
                     : 20'(signed'({1'b0, col_ff, 1'b0}));
      dx1 = fliph_ff ? dx0 - 20'sd1 : dx0 + 20'sd1;
      py  = 20'(oy_ff) + dy;
      px0 = 20'(ox_ff) + dx0;
      px1 = 20'(ox_ff) + dx1;
      v0  = (req.sprite_data[7:4] != 4'd0) && py >= 0 && py < 20'(SCREEN_HEIGHT)
            && px0 >= 0 && px0 < 20'(SCREEN_WIDTH);
      v1  = (req.sprite_data[3:0] != 4'd0) && py >= 0 && py < 20'(SCREEN_HEIGHT)
            && px1 >= 0 && px1 < 20'(SCREEN_WIDTH);
      a0w = (AW+11)'(py[10:0]) * (AW+11)'(SCREEN_WIDTH) + (AW+11)'(px0[10:0]);
      a1w = (AW+11)'(py[10:0]) * (AW+11)'(SCREEN_WIDTH) + (AW+11)'(px1[10:0]);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(FRAME - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer) begin
               if (cmd_type'(req.cmd) == CMD_BYTE && walk_active)
                  state_in = ST_PIX0;
               else if (cmd_type'(req.cmd) == CMD_SCAN)
                  state_in = ST_SCAN;
               else
                  state_in = ST_OUT;
            end
         end
         ST_PIX0: state_in = ST_PIX1;
         ST_PIX1: state_in = ST_OUT;
         ST_SCAN: state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port control.
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = addr0_ff;
      mem_wd   = data_ff[7:4];
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1; mem_addr = clr_ff; mem_wd = 4'd0;
         end
         ST_IDLE: mem_addr = (cmd_type'(req.cmd) == CMD_SCAN) ? AW'(req.pixel_address)
                                                               : AW'(a0w);
         ST_PIX0: begin
            mem_we = vis0_ff; mem_addr = addr0_ff; mem_wd = data_ff[7:4];
         end
         ST_PIX1: begin
            mem_we = vis1_ff; mem_addr = addr1_ff; mem_wd = data_ff[3:0];
         end
         default: ;
      endcase
   end

   // Collision and walk update.
   always_comb begin
      coll_in = coll_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (state_ff == ST_IDLE && req_xfer && cmd_type'(req.cmd) == CMD_START) begin
         coll_in = 1'b0; col_in = 8'd0; row_in = 8'd0;
      end
      if (state_ff == ST_IDLE && req_xfer && cmd_type'(req.cmd) == CMD_BYTE
          && walk_active) begin
         if (col_ff + 8'd1 >= width_ff || col_ff == 8'hFF) begin
            col_in = 8'd0; row_in = row_ff + 8'd1;
         end else begin
            col_in = col_ff + 8'd1;
         end
      end
      // Pixel 0 read data appears in PIX0 (read in IDLE).
      if (state_ff == ST_PIX0 && vis0_ff && mem_rd != 4'd0) coll_in = 1'b1;
      // Pixel 1 is read during its own write in PIX1; the old index arrives in OUT.
      // The two pixels always land in different columns, so no forwarding is needed.
      if (state_ff == ST_OUT && vis1_ff && mem_rd != 4'd0) coll_in = 1'b1;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         width_ff <= '0; height_ff <= '0; fliph_ff <= 1'b0; flipv_ff <= 1'b0; bg_ff <= '0;
         ox_ff <= '0; oy_ff <= '0; col_ff <= '0; row_ff <= '0; coll_ff <= 1'b0;
         for (int i = 0; i < 16; i++) pal_ff[i] <= default_colour(4'(i));
      end else begin
         state_ff <= state_in;
         coll_ff <= coll_in; col_ff <= col_in; row_ff <= row_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr.valid) begin
            case (csr_index_type'(csr.index))
               CSR_WIDTH:  width_ff  <= csr.data;
               CSR_HEIGHT: height_ff <= csr.data;
               CSR_FLIPH:  fliph_ff  <= csr.data[0];
               CSR_FLIPV:  flipv_ff  <= csr.data[0];
               CSR_BACKGR: bg_ff     <= csr.data[3:0];
               default: ;
            endcase
         end
         if (req_xfer && cmd_type'(req.cmd) == CMD_START) begin
            ox_ff <= req.origin_x; oy_ff <= req.origin_y;
         end
         if (req_xfer && cmd_type'(req.cmd) == CMD_PAL)
            pal_ff[req.palette_slot] <= req.palette_colour;
         if (state_ff == ST_OUT) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
   end

   // Per-item payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         data_ff  <= req.sprite_data;
         vis0_ff  <= v0 && cmd_type'(req.cmd) == CMD_BYTE && walk_active;
         vis1_ff  <= v1 && cmd_type'(req.cmd) == CMD_BYTE && walk_active;
         addr0_ff <= AW'(a0w);
         addr1_ff <= AW'(a1w);
         last_ff  <= 1'b0;
         done_ff  <= 1'b0;
         oc_ff <= 1'b0; os_ff <= '0; of_ff <= 1'b0;
         case (cmd_type'(req.cmd))
            CMD_START: done_ff <= (width_ff == 8'd0) || (height_ff == 8'd0);
            CMD_BYTE:  last_ff <= walk_active
                                  && (col_ff + 8'd1 >= width_ff || col_ff == 8'hFF)
                                  && (row_ff + 8'd1 >= height_ff);
            default: ;
         endcase
         od_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         if (int'(req_addr_hold) < FRAME) begin
            os_ff <= pal_ff[(mem_rd == 4'd0) ? bg_ff : mem_rd];
            of_ff <= (int'(req_addr_hold) == FRAME - 1);
         end
      end
      if (state_ff == ST_OUT) begin
         oc_ff <= coll_in;
         od_ff <= done_ff || last_ff;
      end
   end

   // Full scanout address, kept to reject addresses beyond the frame.
   always_ff @(posedge clock) begin
      if (req_xfer) req_addr_hold <= req.pixel_address;
   end

   // A collision is reported only for sprite bytes; other items show zero.
   always_ff @(posedge clock) begin
      if (req_xfer) was_byte_ff <= (cmd_type'(req.cmd) == CMD_BYTE);
   end

   assign rsp.valid       = rv_ff;
   assign rsp.collided    = oc_ff && was_byte_ff;
   assign rsp.sprite_done = od_ff;
   assign rsp.scan_colour = os_ff;
   assign rsp.frame_end   = of_ff;
endmodule
